// ===== rtl/core/ipv4_udp_checksum_generator_top_defines.svh =====
// assertion macros shared by the checksum generator rtl
`ifndef IPV4_UDP_CHECKSUM_GENERATOR_TOP_DEFINES_SVH
`define IPV4_UDP_CHECKSUM_GENERATOR_TOP_DEFINES_SVH

// same-cycle implication, checked at every rising clock edge outside reset
`define IPV4CS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked at every rising clock edge outside reset
`define IPV4CS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/ipv4cs_pkg.sv =====
// shared types and constants of the ipv4/udp checksum generator
`default_nettype none
package ipv4cs_pkg;

   localparam logic [15:0] MAX_PAYLOAD          = 16'd1472;
   localparam logic [15:0] UDP_HDR_LEN          = 16'd8;
   localparam logic [15:0] IP_UDP_HDR_LEN       = 16'd28;
   localparam logic [15:0] VERSION_SERVICE_RST  = 16'h4500;
   localparam logic [15:0] TTL_PROTO_RST        = 16'h8011;
   localparam logic [15:0] COUNT_SATURATED      = 16'hFFFF;
   localparam logic [15:0] ZERO_CHECKSUM_ALT    = 16'hFFFF;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   localparam int unsigned CSR_AW = 5;

   typedef enum logic [2:0] {
      REG_SOURCE_ADDRESS  = 3'd0,
      REG_DEST_ADDRESS    = 3'd1,
      REG_SOURCE_PORT     = 3'd2,
      REG_DEST_PORT       = 3'd3,
      REG_VERSION_SERVICE = 3'd4,
      REG_FLAGS_FRAGMENT  = 3'd5,
      REG_TTL_PROTO       = 3'd6,
      REG_IDENT_REQUEST   = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [31:0] source_address;
      logic [31:0] dest_address;
      logic [15:0] source_port;
      logic [15:0] dest_port;
      logic [15:0] version_service;
      logic [15:0] flags_fragment;
      logic [15:0] ttl_proto;
      logic [15:0] ident_request;
   } cfg_type;

   // one closed datagram handed from the front to the back
   typedef struct packed {
      logic [31:0] payload_sum;
      logic [15:0] byte_count;
   } dgram_type;

   // queue status seen by both ends
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage
`default_nettype wire

// ===== rtl/core/ipv4cs_front.sv =====
// payload front end: byte pairing, ones-complement payload sum, byte count
`default_nettype none
module ipv4cs_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  byte_valid,
   input  wire logic [7:0]            payload_byte,
   input  wire logic                  last_byte,
   output      logic                  byte_ready,
   input  wire ipv4cs_pkg::queue_status_type q_status,
   output      logic                  push,
   output      ipv4cs_pkg::dgram_type push_data
);
   import ipv4cs_pkg::*;
`include "ipv4_udp_checksum_generator_top_defines.svh"

   logic [31:0] sum_ff, sum_in;
   logic [15:0] count_ff, count_in;
   logic [7:0]  held_ff, held_in;
   logic        odd_ff, odd_in;

   logic        take;
   logic        add_en;
   logic [15:0] word;
   logic [32:0] add_wide;
   logic [31:0] sum_upd;
   logic [15:0] count_upd;

   assign byte_ready = !q_status.full;
   assign take       = byte_valid && byte_ready;

   // odd phase pairs with the held byte; a lone final byte pads with zero
   always_comb begin
      word   = odd_ff ? {held_ff, payload_byte} : {payload_byte, 8'h00};
      add_en = odd_ff || last_byte;
   end

   // end-around carry: a carry out can only leave a small residue, so no second carry
   assign add_wide  = {1'b0, sum_ff} + {17'd0, word};
   assign sum_upd   = add_en ? (add_wide[31:0] + {31'd0, add_wide[32]}) : sum_ff;
   assign count_upd = (count_ff == COUNT_SATURATED) ? count_ff : count_ff + 16'd1;

   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      held_in  = held_ff;
      odd_in   = odd_ff;
      if (take) begin
         if (last_byte) begin
            sum_in   = '0;
            count_in = '0;
            held_in  = '0;
            odd_in   = 1'b0;
         end else begin
            sum_in   = sum_upd;
            count_in = count_upd;
            held_in  = payload_byte;
            odd_in   = !odd_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
         held_ff  <= '0;
         odd_ff   <= 1'b0;
      end else begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
         held_ff  <= held_in;
         odd_ff   <= odd_in;
      end
   end

   assign push                  = take && last_byte;
   assign push_data.payload_sum = sum_upd;
   assign push_data.byte_count  = count_upd;

   `IPV4CS_ASSERT_NEXT(a_front_clears, clock, reset, push,
      (sum_ff == 32'd0) && (count_ff == 16'd0) && !odd_ff, "datagram state not cleared")

endmodule
`default_nettype wire

// ===== rtl/core/ipv4cs_queue.sv =====
// short queue of closed datagram records between front and back
`default_nettype none
module ipv4cs_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire ipv4cs_pkg::dgram_type push_data,
   input  wire logic                  pop,
   output      ipv4cs_pkg::dgram_type pop_data,
   output      ipv4cs_pkg::queue_status_type status
);
   import ipv4cs_pkg::*;
`include "ipv4_udp_checksum_generator_top_defines.svh"

   dgram_type             entries_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   assign status.full  = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   `IPV4CS_ASSERT_SAME(a_queue_no_overflow, clock, reset, push, !status.full,
      "push into full queue")
   `IPV4CS_ASSERT_SAME(a_queue_no_underflow, clock, reset, pop, !status.empty,
      "pop from empty queue")
   `IPV4CS_ASSERT_SAME(a_queue_count_bound, clock, reset, 1'b1,
      count_ff <= QUEUE_CW'(QUEUE_DEPTH), "queue count beyond depth")

endmodule
`default_nettype wire

// ===== rtl/core/ipv4cs_back.sv =====
// checksum back end: lengths, identification, header and udp sums, fold, output register
`default_nettype none
module ipv4cs_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ipv4cs_pkg::cfg_type   cfg,
   input  wire ipv4cs_pkg::queue_status_type q_status,
   input  wire ipv4cs_pkg::dgram_type pop_data,
   output      logic                  pop,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output      logic [15:0]           header_checksum,
   output      logic [15:0]           datagram_checksum,
   output      logic [15:0]           ip_total_len,
   output      logic [15:0]           datagram_length,
   output      logic [15:0]           identification,
   output      logic                  length_error
);
   import ipv4cs_pkg::*;
`include "ipv4_udp_checksum_generator_top_defines.svh"

   // valid bits
   logic s1_v_ff, s1_v_in, s2_v_ff, s2_v_in, s3_v_ff, s3_v_in, o_v_ff, o_v_in;
   logic s1_rdy, s2_rdy, s3_rdy, o_rdy;

   logic [15:0] ident_cnt_ff, ident_cnt_in;

   // stage 1: lengths and identification
   logic [31:0] s1_psum_ff;
   logic [15:0] s1_dlen_ff, s1_tot_ff, s1_ident_ff;
   logic        s1_err_ff;
   // stage 2: raw sums
   logic [19:0] s2_hsum_ff;
   logic [35:0] s2_usum_ff;
   logic [15:0] s2_dlen_ff, s2_tot_ff, s2_ident_ff;
   logic        s2_err_ff;
   // stage 3: partially folded sums
   logic [16:0] s3_hsum_ff, s3_usum_ff;
   logic [15:0] s3_dlen_ff, s3_tot_ff, s3_ident_ff;
   logic        s3_err_ff;
   // output register
   logic [15:0] o_hck_ff, o_uck_ff, o_dlen_ff, o_tot_ff, o_ident_ff;
   logic        o_err_ff;

   logic [15:0] cnt_next, ident_pick;
   logic [19:0] hsum_raw;
   logic [35:0] usum_raw;
   logic [20:0] u_fold1;
   logic [16:0] h_fold, u_fold2;
   logic [15:0] h_done, u_done, u_ck;

   assign o_rdy  = !o_v_ff || rsp_ready;
   assign s3_rdy = !s3_v_ff || o_rdy;
   assign s2_rdy = !s2_v_ff || s3_rdy;
   assign s1_rdy = !s1_v_ff || s2_rdy;
   assign pop    = !q_status.empty && s1_rdy;

   always_comb begin
      s1_v_in = s1_rdy ? pop     : s1_v_ff;
      s2_v_in = s2_rdy ? s1_v_ff : s2_v_ff;
      s3_v_in = s3_rdy ? s2_v_ff : s3_v_ff;
      o_v_in  = o_rdy  ? s3_v_ff : o_v_ff;
   end

   // counter only advances for datagrams that use it
   assign cnt_next   = ident_cnt_ff + 16'd1;
   assign ident_pick = (cfg.ident_request != 16'd0) ? cfg.ident_request : cnt_next;
   assign ident_cnt_in = (pop && (cfg.ident_request == 16'd0)) ? cnt_next : ident_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         s3_v_ff      <= 1'b0;
         o_v_ff       <= 1'b0;
         ident_cnt_ff <= '0;
      end else begin
         s1_v_ff      <= s1_v_in;
         s2_v_ff      <= s2_v_in;
         s3_v_ff      <= s3_v_in;
         o_v_ff       <= o_v_in;
         ident_cnt_ff <= ident_cnt_in;
      end
   end

   always_comb begin
      hsum_raw = {4'd0, cfg.version_service} + {4'd0, s1_tot_ff} + {4'd0, s1_ident_ff}
               + {4'd0, cfg.flags_fragment} + {4'd0, cfg.ttl_proto}
               + {4'd0, cfg.source_address[31:16]} + {4'd0, cfg.source_address[15:0]}
               + {4'd0, cfg.dest_address[31:16]} + {4'd0, cfg.dest_address[15:0]};
      usum_raw = {4'd0, s1_psum_ff}
               + {20'd0, cfg.source_address[31:16]} + {20'd0, cfg.source_address[15:0]}
               + {20'd0, cfg.dest_address[31:16]} + {20'd0, cfg.dest_address[15:0]}
               + {28'd0, cfg.ttl_proto[7:0]} + {20'd0, s1_dlen_ff}
               + {20'd0, cfg.source_port} + {20'd0, cfg.dest_port} + {20'd0, s1_dlen_ff};
   end

   // end-around folds, spread over two stages
   always_comb begin
      h_fold  = {1'b0, s2_hsum_ff[15:0]} + {13'd0, s2_hsum_ff[19:16]};
      u_fold1 = {5'd0, s2_usum_ff[15:0]} + {1'b0, s2_usum_ff[35:16]};
      u_fold2 = {1'b0, u_fold1[15:0]} + {12'd0, u_fold1[20:16]};
      h_done  = s3_hsum_ff[15:0] + {15'd0, s3_hsum_ff[16]};
      u_done  = s3_usum_ff[15:0] + {15'd0, s3_usum_ff[16]};
      u_ck    = ~u_done;
      if (u_ck == 16'd0) begin
         u_ck = ZERO_CHECKSUM_ALT;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_rdy) begin
         s1_psum_ff  <= pop_data.payload_sum;
         s1_dlen_ff  <= pop_data.byte_count + UDP_HDR_LEN;
         s1_tot_ff   <= pop_data.byte_count + IP_UDP_HDR_LEN;
         s1_ident_ff <= ident_pick;
         s1_err_ff   <= pop_data.byte_count > MAX_PAYLOAD;
      end
      if (s2_rdy) begin
         s2_hsum_ff  <= hsum_raw;
         s2_usum_ff  <= usum_raw;
         s2_dlen_ff  <= s1_dlen_ff;
         s2_tot_ff   <= s1_tot_ff;
         s2_ident_ff <= s1_ident_ff;
         s2_err_ff   <= s1_err_ff;
      end
      if (s3_rdy) begin
         s3_hsum_ff  <= h_fold;
         s3_usum_ff  <= u_fold2;
         s3_dlen_ff  <= s2_dlen_ff;
         s3_tot_ff   <= s2_tot_ff;
         s3_ident_ff <= s2_ident_ff;
         s3_err_ff   <= s2_err_ff;
      end
      if (o_rdy) begin
         o_hck_ff   <= ~h_done;
         o_uck_ff   <= u_ck;
         o_dlen_ff  <= s3_dlen_ff;
         o_tot_ff   <= s3_tot_ff;
         o_ident_ff <= s3_ident_ff;
         o_err_ff   <= s3_err_ff;
      end
   end

   assign rsp_valid         = o_v_ff;
   assign header_checksum   = o_hck_ff;
   assign datagram_checksum = o_uck_ff;
   assign ip_total_len      = o_tot_ff;
   assign datagram_length   = o_dlen_ff;
   assign identification    = o_ident_ff;
   assign length_error      = o_err_ff;

   `IPV4CS_ASSERT_SAME(a_back_udp_nonzero, clock, reset, o_v_ff, o_uck_ff != 16'd0,
      "udp checksum of zero sent")
   `IPV4CS_ASSERT_SAME(a_back_length_gap, clock, reset, o_v_ff,
      (o_tot_ff - o_dlen_ff) == (IP_UDP_HDR_LEN - UDP_HDR_LEN), "length fields disagree")

endmodule
`default_nettype wire

// ===== rtl/core/ipv4_udp_checksum_generator_top.sv =====
// top level of the ipv4 header and udp checksum generator with its register file
`default_nettype none
// Streams udp payload bytes in on req_ (one byte per transaction, tlast on the final
// byte) and returns one transaction on rsp_ per datagram with the ipv4 header checksum,
// the udp checksum over pseudo-header, udp header and payload, both lengths, the
// identification used and an overlength flag. The byte stream is taken at one byte per
// clock while the queue is not full; the front end does one 32-bit end-around add per
// byte pair (or lone final byte). Each closed datagram becomes a record in a four-entry
// queue; the back end works it through three register stages and an output register,
// and datagrams of any size (even one byte) follow back to back. Backpressure on rsp_
// fills the back pipeline, then the queue, and only then drops req_tready. Header
// fields, ports and the identification request sit in csr_ registers (byte address
// 4*index); write them only while no datagram is in flight. The block does not check.
module ipv4_udp_checksum_generator_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request stream
   input  wire logic                          req_tvalid,
   output      logic                          req_tready,
   input  wire logic [7:0]                    req_tdata,   // [7:0] payload_byte
   input  wire logic                          req_tlast,   // last_byte
   // result stream
   output      logic                          rsp_tvalid,
   input  wire logic                          rsp_tready,
   // [15:0] header_checksum, [31:16] datagram_checksum, [47:32] ip_total_len,
   // [63:48] datagram_length, [79:64] identification
   output      logic [79:0]                   rsp_tdata,
   output      logic                          rsp_tuser,   // length_error
   // register port
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [ipv4cs_pkg::CSR_AW-1:0] csr_paddr,
   input  wire logic [31:0]                   csr_pwdata,
   output      logic [31:0]                   csr_prdata,
   output      logic                          csr_pready
);
   import ipv4cs_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   csr_index_type    csr_idx;
   logic             csr_wr;

   queue_status_type q_status;
   logic             q_push, q_pop;
   dgram_type        q_push_data, q_pop_data;

   logic [15:0] o_hck, o_uck, o_tot, o_dlen, o_ident;
   logic        o_err;

   // register file: word-aligned, low two address bits ignored
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_index_type'(csr_paddr[CSR_AW-1:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_SOURCE_ADDRESS:  cfg_in.source_address  = csr_pwdata;
            REG_DEST_ADDRESS:    cfg_in.dest_address    = csr_pwdata;
            REG_SOURCE_PORT:     cfg_in.source_port     = csr_pwdata[15:0];
            REG_DEST_PORT:       cfg_in.dest_port       = csr_pwdata[15:0];
            REG_VERSION_SERVICE: cfg_in.version_service = csr_pwdata[15:0];
            REG_FLAGS_FRAGMENT:  cfg_in.flags_fragment  = csr_pwdata[15:0];
            REG_TTL_PROTO:       cfg_in.ttl_proto       = csr_pwdata[15:0];
            REG_IDENT_REQUEST:   cfg_in.ident_request   = csr_pwdata[15:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   // readback of the addressed register, 16-bit ones zero-extended
   always_comb begin
      case (csr_idx)
         REG_SOURCE_ADDRESS:  csr_prdata = cfg_ff.source_address;
         REG_DEST_ADDRESS:    csr_prdata = cfg_ff.dest_address;
         REG_SOURCE_PORT:     csr_prdata = {16'd0, cfg_ff.source_port};
         REG_DEST_PORT:       csr_prdata = {16'd0, cfg_ff.dest_port};
         REG_VERSION_SERVICE: csr_prdata = {16'd0, cfg_ff.version_service};
         REG_FLAGS_FRAGMENT:  csr_prdata = {16'd0, cfg_ff.flags_fragment};
         REG_TTL_PROTO:       csr_prdata = {16'd0, cfg_ff.ttl_proto};
         REG_IDENT_REQUEST:   csr_prdata = {16'd0, cfg_ff.ident_request};
         default:             csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.source_address  <= '0;
         cfg_ff.dest_address    <= '0;
         cfg_ff.source_port     <= '0;
         cfg_ff.dest_port       <= '0;
         cfg_ff.version_service <= VERSION_SERVICE_RST;
         cfg_ff.flags_fragment  <= '0;
         cfg_ff.ttl_proto       <= TTL_PROTO_RST;
         cfg_ff.ident_request   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front end: pairs bytes and keeps the running payload sum and count
   ipv4cs_front u_front (
      .clock        (clock),
      .reset        (reset),
      .byte_valid   (req_tvalid),
      .payload_byte (req_tdata),
      .last_byte    (req_tlast),
      .byte_ready   (req_tready),
      .q_status     (q_status),
      .push         (q_push),
      .push_data    (q_push_data)
   );

   // closed datagrams wait here so the front keeps taking bytes under rsp_ stalls
   ipv4cs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .status    (q_status)
   );

   // back end: header fields, checksums and the result register
   ipv4cs_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .q_status          (q_status),
      .pop_data          (q_pop_data),
      .pop               (q_pop),
      .rsp_valid         (rsp_tvalid),
      .rsp_ready         (rsp_tready),
      .header_checksum   (o_hck),
      .datagram_checksum (o_uck),
      .ip_total_len      (o_tot),
      .datagram_length   (o_dlen),
      .identification    (o_ident),
      .length_error      (o_err)
   );

   // result packing, first field lowest
   assign rsp_tdata = {o_ident, o_dlen, o_tot, o_uck, o_hck};
   assign rsp_tuser = o_err;

endmodule
`default_nettype wire
